@@ hdl/cdsm_pkg.sv @@
// Shared types and constants for the core dispatch state machine.
// No dependencies; used by cdsm_step and core_dispatch_state_machine_core.
`timescale 1ns / 1ps

package cdsm_pkg;

    localparam int DEF_CORE_COUNT     = 64;
    localparam int DEF_THREAD_ID_BITS = 12;

    localparam int TID_W     = 12;
    localparam int HINT_W    = 32;
    localparam int CORE_W    = 8;
    localparam int REQ_W     = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 64;

    localparam logic [REQ_W-1:0] REQ_RUN         = 3'd0;
    localparam logic [REQ_W-1:0] REQ_IDLE        = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SWITCH_DONE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WENT_IDLE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_CORES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_REWAKE   = 4'd1;

    // slot flag positions (LSBs of a packed slot)
    localparam int SLOT_WAIT_BIT = 0;
    localparam int SLOT_PEND_BIT = 1;
    localparam int SLOT_IDLE_BIT = 2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CORE_W-1:0] core_index;
        logic              thread_valid;
        logic [TID_W-1:0]  thread_id;
        logic [HINT_W-1:0] idle_hint;
        logic              rewake_possible;
    } in_word_t;

    typedef struct packed {
        logic              status;
        logic              issue_run;
        logic              run_thread_valid;
        logic [TID_W-1:0]  run_thread_id;
        logic              send_cede;
        logic              release_valid;
        logic [TID_W-1:0]  release_thread_id;
        logic              release_keeps_affinity;
        logic              core_now_idle;
        logic              current_valid;
        logic [TID_W-1:0]  current_thread_id;
        logic [HINT_W-1:0] idle_hint_out;
    } out_word_t;

    // current, previous and pending thread (valid + id each) plus three flags
    function automatic int slot_width(input int tid_bits);
        return 3 * (tid_bits + 1) + 3;
    endfunction

endpackage

@@ hdl/cdsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cdsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/cdsm_step.sv @@
// Request decode and slot update for one core slot, purely combinational.
// Depends on cdsm_pkg.
`timescale 1ns / 1ps

module cdsm_step #(
    parameter int CORE_COUNT     = cdsm_pkg::DEF_CORE_COUNT,
    parameter int THREAD_ID_BITS = cdsm_pkg::DEF_THREAD_ID_BITS
) (
    input  cdsm_pkg::in_word_t                                      req,
    input  logic [cdsm_pkg::slot_width(THREAD_ID_BITS)-1:0]         slot_in,
    input  logic [CORE_COUNT-1:0]                                   allowed,
    input  logic                                                    fast_rewake,
    output logic [cdsm_pkg::slot_width(THREAD_ID_BITS)-1:0]         slot_out,
    output logic                                                    slot_we,
    output cdsm_pkg::out_word_t                                     result
);

    localparam int CoreW = $clog2(CORE_COUNT);

    typedef struct packed {
        logic                      cur_v;
        logic [THREAD_ID_BITS-1:0] cur_id;
        logic                      last_v;
        logic [THREAD_ID_BITS-1:0] last_id;
        logic                      pend_v;
        logic [THREAD_ID_BITS-1:0] pend_id;
        logic                      flag_idle;
        logic                      flag_pend;
        logic                      flag_wait;
    } slot_t;

    slot_t               s;
    cdsm_pkg::out_word_t r;
    logic                ok;
    logic                dv;
    logic [THREAD_ID_BITS-1:0] did;
    logic [THREAD_ID_BITS-1:0] tid;

    always_comb
    begin
        s   = slot_t'(slot_in);
        r   = '0;
        tid = THREAD_ID_BITS'(req.thread_id);
        dv  = 1'b0;
        did = '0;

        ok = ({1'b0, req.core_index} < 9'(CORE_COUNT)) && (req.req_type <= cdsm_pkg::REQ_QUERY);
        if (ok && req.req_type != cdsm_pkg::REQ_QUERY)
        begin
            ok = allowed[req.core_index[CoreW-1:0]];
        end
        if (ok && req.req_type == cdsm_pkg::REQ_RUN && !req.thread_valid)
        begin
            ok = 1'b0;
        end

        if (!ok)
        begin
            r.status = 1'b1;
        end
        else
        begin
            unique case (req.req_type)
                cdsm_pkg::REQ_RUN, cdsm_pkg::REQ_IDLE:
                begin
                    dv  = (req.req_type == cdsm_pkg::REQ_RUN);
                    did = dv ? tid : '0;
                    if (req.req_type == cdsm_pkg::REQ_IDLE)
                    begin
                        r.idle_hint_out = req.idle_hint;
                    end
                    if (s.flag_wait)
                    begin
                        // deferred: replace pending thread
                        if (s.flag_pend && s.pend_v)
                        begin
                            r.release_valid     = 1'b1;
                            r.release_thread_id = cdsm_pkg::TID_W'(s.pend_id);
                        end
                        s.pend_v    = dv;
                        s.pend_id   = did;
                        s.flag_pend = 1'b1;
                    end
                    else
                    begin
                        r.send_cede        = !s.flag_idle && s.cur_v;
                        r.issue_run        = 1'b1;
                        r.run_thread_valid = dv;
                        r.run_thread_id    = cdsm_pkg::TID_W'(did);
                        s.last_v           = s.cur_v;
                        s.last_id          = s.cur_id;
                        s.cur_v            = dv;
                        s.cur_id           = did;
                        s.flag_wait        = 1'b1;
                        s.flag_idle        = 1'b0;
                    end
                end
                cdsm_pkg::REQ_SWITCH_DONE:
                begin
                    if (s.flag_wait)
                    begin
                        if (s.last_v)
                        begin
                            r.release_valid          = 1'b1;
                            r.release_thread_id      = cdsm_pkg::TID_W'(s.last_id);
                            r.release_keeps_affinity = 1'b1;
                            s.last_v                 = 1'b0;
                            s.last_id                = '0;
                        end
                        if (s.flag_pend)
                        begin
                            dv                 = s.pend_v;
                            did                = s.pend_id;
                            s.pend_v           = 1'b0;
                            s.pend_id          = '0;
                            s.flag_pend        = 1'b0;
                            r.send_cede        = 1'b1;
                            r.issue_run        = 1'b1;
                            r.run_thread_valid = dv;
                            r.run_thread_id    = dv ? cdsm_pkg::TID_W'(did) : '0;
                            s.last_v           = s.cur_v;
                            s.last_id          = s.cur_id;
                            s.cur_v            = dv;
                            s.cur_id           = did;
                        end
                        else
                        begin
                            s.flag_wait = 1'b0;
                        end
                    end
                end
                cdsm_pkg::REQ_WENT_IDLE:
                begin
                    if (!s.flag_wait && !s.flag_idle)
                    begin
                        if (s.cur_v && fast_rewake && req.rewake_possible)
                        begin
                            r.issue_run        = 1'b1;
                            r.run_thread_valid = 1'b1;
                            r.run_thread_id    = cdsm_pkg::TID_W'(s.cur_id);
                            s.flag_wait        = 1'b1;
                        end
                        else
                        begin
                            if (s.cur_v)
                            begin
                                r.release_valid          = 1'b1;
                                r.release_thread_id      = cdsm_pkg::TID_W'(s.cur_id);
                                r.release_keeps_affinity = 1'b1;
                                s.cur_v                  = 1'b0;
                                s.cur_id                 = '0;
                            end
                            s.flag_idle     = 1'b1;
                            r.core_now_idle = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (s.flag_pend)
            begin
                r.current_valid     = s.pend_v;
                r.current_thread_id = s.pend_v ? cdsm_pkg::TID_W'(s.pend_id) : '0;
            end
            else
            begin
                r.current_valid     = s.cur_v;
                r.current_thread_id = s.cur_v ? cdsm_pkg::TID_W'(s.cur_id) : '0;
            end
        end
    end

    assign slot_out = s;
    assign slot_we  = ok;
    assign result   = r;

endmodule

@@ hdl/core_dispatch_state_machine_core.sv @@
// Top level of the core dispatch state machine: request register, slot table RAM,
// slot update logic and result register. Depends on cdsm_pkg, cdsm_ram, cdsm_step.
`timescale 1ns / 1ps

// Takes one request per clock (start while busy is low) and returns exactly one
// result word per request, through the request and result registers, marked by a one-cycle done
// strobe. The receiver cannot stall: a result word is gone after its done cycle.
// Sustained rate is one request per cycle, set by the slot table's single read and
// write port; back-to-back requests to the same core are forwarded around the RAM.
// busy is high only in the first cycle after reset; slot valid bits make reset
// instant, with no clearing pass. Configuration writes are always taken
// (cfg_ready high) and must be made only while no request is in flight.

module core_dispatch_state_machine_core #(
    parameter int CORE_COUNT     = cdsm_pkg::DEF_CORE_COUNT,
    parameter int THREAD_ID_BITS = cdsm_pkg::DEF_THREAD_ID_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  cdsm_pkg::in_word_t                request,
    output logic                              done,
    output cdsm_pkg::out_word_t               result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdsm_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int CoreW = $clog2(CORE_COUNT);
    localparam int SlotW = cdsm_pkg::slot_width(THREAD_ID_BITS);

    logic                 busy_reg;
    logic [CORE_COUNT-1:0] allowed_reg;
    logic                 rewake_en_reg;

    logic                 s1_valid_reg;
    cdsm_pkg::in_word_t   s1_req_reg;

    logic [CORE_COUNT-1:0] slot_valid_reg;
    logic                 fwd_valid_reg;
    logic [CoreW-1:0]     fwd_core_reg;
    logic [SlotW-1:0]     fwd_data_reg;

    logic                 done_reg;
    cdsm_pkg::out_word_t  result_reg;

    logic                 accept;
    logic [CoreW-1:0]     s1_core;
    logic [SlotW-1:0]     ram_rd_data;
    logic [SlotW-1:0]     slot_cur;
    logic [SlotW-1:0]     slot_new;
    logic                 slot_ok;
    logic                 wr_en;
    cdsm_pkg::out_word_t  step_result;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;
    assign s1_core   = s1_req_reg.core_index[CoreW-1:0];
    assign wr_en     = s1_valid_reg && slot_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            allowed_reg   <= '0;
            rewake_en_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    cdsm_pkg::CFG_ALLOWED_CORES: allowed_reg   <= cfg_data[CORE_COUNT-1:0];
                    cdsm_pkg::CFG_FAST_REWAKE:   rewake_en_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    cdsm_ram #(
        .WIDTH (SlotW),
        .DEPTH (CORE_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_core),
        .wr_data (slot_new),
        .rd_addr (request.core_index[CoreW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        if (fwd_valid_reg && fwd_core_reg == s1_core)
        begin
            slot_cur = fwd_data_reg;
        end
        else if (slot_valid_reg[s1_core])
        begin
            slot_cur = ram_rd_data;
        end
        else
        begin
            slot_cur = '0;
        end
    end

    cdsm_step #(
        .CORE_COUNT     (CORE_COUNT),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_step (
        .req         (s1_req_reg),
        .slot_in     (slot_cur),
        .allowed     (allowed_reg),
        .fast_rewake (rewake_en_reg),
        .slot_out    (slot_new),
        .slot_we     (slot_ok),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            slot_valid_reg <= '0;
            fwd_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= wr_en;
            done_reg      <= s1_valid_reg;
            if (wr_en)
            begin
                slot_valid_reg[s1_core] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= request;
        end
        fwd_core_reg <= s1_core;
        fwd_data_reg <= slot_new;
        result_reg   <= step_result;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted request produced no result two cycles later");

    a_pend_needs_wait: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !(slot_new[cdsm_pkg::SLOT_PEND_BIT] && !slot_new[cdsm_pkg::SLOT_WAIT_BIT]))
        else $error("slot written with pending thread but no switch in progress");

    a_idle_not_wait: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !(slot_new[cdsm_pkg::SLOT_IDLE_BIT] && slot_new[cdsm_pkg::SLOT_WAIT_BIT]))
        else $error("slot written both idle and waiting");

    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (!result.issue_run && !result.release_valid
                                     && !result.send_cede && !result.core_now_idle))
        else $error("rejected request produced side effects");

    a_rejected_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && step_result.status) |-> !wr_en)
        else $error("rejected request updated the slot table");

endmodule
